>>> rtl/pdrh_pkg.sv
package pdrh_pkg;

	// Fixed field widths
	localparam int unsigned PIX_W = 16;
	localparam int unsigned P8_W  = 8;
	localparam int unsigned CNT_W = 21;
	localparam int unsigned DEP_W = 5;
	localparam int unsigned CFG_W = 21;
	localparam int unsigned CIX_W = 2;

	// Request kinds
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	// Configuration register indexes
	localparam logic [CIX_W-1:0] CFG_BIT_DEPTH    = 2'd0;
	localparam logic [CIX_W-1:0] CFG_FRAME_PIXELS = 2'd1;
	localparam logic [CIX_W-1:0] CFG_INPUT_8BIT   = 2'd2;

	// Reset values of the configuration registers
	localparam logic [DEP_W-1:0] BIT_DEPTH_RST    = 5'd8;
	localparam logic [CNT_W-1:0] FRAME_PIXELS_RST = 21'd1048576;

	// Saturation value of a bin count
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef struct packed {
		logic             req_type;
		logic [PIX_W-1:0] pixel_value;
		logic [7:0]       bin_index;
	} req_t;

	typedef struct packed {
		logic             reply_kind;
		logic [P8_W-1:0]  pixel_8bit;
		logic [CNT_W-1:0] bin_count;
		logic             frame_done;
		logic             histogram_ready;
	} rsp_t;

	// Per-transaction result of the frame/tag lookup
	typedef struct packed {
		logic hit;
		logic done;
		logic hist_ready;
	} frame_ctl_t;

endpackage

>>> rtl/pdrh_scale.sv
// Depth reduction of a raw sample and the histogram bin it falls into
module pdrh_scale #(
	parameter int unsigned BIN_COUNT = 256
) (
	input  logic [pdrh_pkg::PIX_W-1:0]  pixel_value,
	input  logic [pdrh_pkg::DEP_W-1:0]  depth,
	input  logic                        is_8bit,
	output logic [pdrh_pkg::P8_W-1:0]   pixel_8bit,
	output logic [$clog2(BIN_COUNT)-1:0] bin_idx
);

	localparam int unsigned IW = $clog2(BIN_COUNT);
	localparam logic [7:0] BinMax = 8'(BIN_COUNT - 1);

	logic [23:0] prod;
	logic [23:0] shifted;
	logic [7:0]  lim_depth;
	logic [7:0]  lim;
	logic [7:0]  idx8;

	// 255*v as (v << 8) - v, then divide by 2^depth
	assign prod    = {pixel_value, 8'd0} - {8'd0, pixel_value};
	assign shifted = prod >> depth;

	always_comb begin
		if (is_8bit) begin
			pixel_8bit = (|pixel_value[15:8]) ? 8'hFF : pixel_value[7:0];
		end else begin
			pixel_8bit = (|shifted[23:8]) ? 8'hFF : shifted[7:0];
		end
	end

	// Clamp to the last bin that exists at this depth
	always_comb begin
		lim_depth = (depth >= 5'd8) ? 8'hFF : 8'((9'd1 << depth) - 9'd1);
		lim       = (lim_depth > BinMax) ? BinMax : lim_depth;
		idx8      = (pixel_8bit > lim) ? lim : pixel_8bit;
		bin_idx   = idx8[IW-1:0];
	end

endmodule

>>> rtl/pdrh_frame.sv
// Frame tracking: per-bin frame tags, current tag, pixel counter
module pdrh_frame #(
	parameter int unsigned BIN_COUNT        = 256,
	parameter int unsigned MAX_FRAME_PIXELS = 1048576
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   accept,
	input  logic                                   is_pixel,
	input  logic                                   in_range,
	input  logic [$clog2(BIN_COUNT)-1:0]           idx,
	input  logic [$clog2(MAX_FRAME_PIXELS+1)-1:0]  eff_frame,
	output pdrh_pkg::frame_ctl_t                   ctl
);

	localparam int unsigned CW = $clog2(MAX_FRAME_PIXELS + 1);

	logic [BIN_COUNT-1:0] tag_q;
	logic                 cur_q;
	logic [CW-1:0]        cnt_q;
	logic                 fc_q;

	logic                 new_frame;
	logic                 cur_nxt;
	logic [CW-1:0]        cnt_inc;
	logic                 done;
	logic [BIN_COUNT-1:0] tag_nxt;

	// A pixel arriving with a zero counter opens a new frame
	assign new_frame = is_pixel && (cnt_q == '0);
	assign cur_nxt   = new_frame ? ~cur_q : cur_q;
	assign cnt_inc   = cnt_q + CW'(1);
	assign done      = is_pixel && (cnt_inc >= eff_frame);

	always_comb begin
		ctl.done = done;
		if (is_pixel) begin
			ctl.hit        = !new_frame && (tag_q[idx] == cur_q);
			ctl.hist_ready = done || (fc_q && !new_frame);
		end else begin
			ctl.hit        = in_range && (tag_q[idx] == cur_q);
			ctl.hist_ready = fc_q;
		end
	end

	// Tags: a new frame retags every bin stale, then the touched bin goes live
	always_comb begin
		tag_nxt      = new_frame ? {BIN_COUNT{cur_q}} : tag_q;
		tag_nxt[idx] = cur_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
			cur_q <= 1'b1;
			cnt_q <= '0;
			fc_q  <= 1'b0;
		end else if (accept && is_pixel) begin
			tag_q <= tag_nxt;
			cur_q <= cur_nxt;
			cnt_q <= done ? '0 : cnt_inc;
			fc_q  <= ctl.hist_ready;
		end
	end

endmodule

>>> rtl/pdrh_bins.sv
// Bin count memory with read-modify-write and write forwarding
module pdrh_bins #(
	parameter int unsigned BIN_COUNT = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [$clog2(BIN_COUNT)-1:0] rd_addr,
	input  logic                         rd_hit,
	input  logic                         rd_is_pixel,
	input  logic                         commit,
	output logic [pdrh_pkg::CNT_W-1:0]   count_s1
);

	localparam int unsigned IW = $clog2(BIN_COUNT);

	logic [pdrh_pkg::CNT_W-1:0] mem_q [BIN_COUNT];
	logic [pdrh_pkg::CNT_W-1:0] rd_data_s1;
	logic [IW-1:0]              addr_s1;
	logic                       hit_s1;
	logic                       is_pixel_s1;

	logic                       fwd_vld_q;
	logic [IW-1:0]              fwd_addr_q;
	logic [pdrh_pkg::CNT_W-1:0] fwd_data_q;

	logic [pdrh_pkg::CNT_W-1:0] base;
	logic [pdrh_pkg::CNT_W-1:0] inc;
	logic                       wr_en;

	// Stale bins read as zero; last write overrides the memory read
	always_comb begin
		if (!hit_s1) begin
			base = '0;
		end else if (fwd_vld_q && (fwd_addr_q == addr_s1)) begin
			base = fwd_data_q;
		end else begin
			base = rd_data_s1;
		end
		inc      = (base == pdrh_pkg::CNT_MAX) ? base : base + pdrh_pkg::CNT_W'(1);
		count_s1 = is_pixel_s1 ? inc : base;
	end

	assign wr_en = commit && is_pixel_s1;

	// Memory: one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr_s1] <= inc;
		end
		if (rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_s1     <= rd_addr;
			hit_s1      <= rd_hit;
			is_pixel_s1 <= rd_is_pixel;
		end
		if (wr_en) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (wr_en) begin
			fwd_vld_q <= 1'b1;
		end
	end

endmodule

>>> rtl/pixel_depth_reduce_histogram.sv
// Pixel bit-depth reducer with a per-frame histogram.
// req channel (req_valid/req_stall/req_data): pixel samples and bin reads.
// rsp channel (rsp_valid/rsp_stall/rsp_data): one response per request, in order.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): bit depth, frame size
// and 8-bit mode; cfg_ready is always high. Write only while the block is idle.
// A request accepted into stage 1 reads the bin memory there; the increment is
// then formed and captured in the output register, which drives the response.
// Throughput: one request per cycle while rsp_stall is low, back to back,
// including repeated pixels of the same bin; the read-modify-write of the bin
// memory forwards the last written count so no bubble is needed.
// Reset clears the frame state: all bins read as zero, no frame complete,
// configuration back to 8-bit depth, 1048576 pixels, scaling mode.
// Bins are cleared per frame through a tag bit per bin, with no clearing pass.
// When rsp_stall is high the output register holds; one more request can be
// taken into the pipeline, after which req_stall rises until rsp drains.
module pixel_depth_reduce_histogram #(
	parameter int unsigned BIN_COUNT        = 256,
	parameter int unsigned MAX_FRAME_PIXELS = 1048576
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  pdrh_pkg::req_t                 req_data,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output pdrh_pkg::rsp_t                 rsp_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pdrh_pkg::CIX_W-1:0]     cfg_index,
	input  logic [pdrh_pkg::CFG_W-1:0]     cfg_data
);

	localparam int unsigned IW = $clog2(BIN_COUNT);
	localparam int unsigned CW = $clog2(MAX_FRAME_PIXELS + 1);
	localparam int unsigned FW = (CW > pdrh_pkg::CNT_W) ? CW : pdrh_pkg::CNT_W;
	localparam logic [FW-1:0] MaxFrame = FW'(MAX_FRAME_PIXELS);
	localparam logic [8:0]    BinLimit = 9'(BIN_COUNT);

	// Configuration registers
	logic [pdrh_pkg::DEP_W-1:0] bit_depth_q;
	logic [pdrh_pkg::CNT_W-1:0] frame_pixels_q;
	logic                       input_8bit_q;

	// Pipeline and output registers
	logic                      valid_s1;
	logic                      kind_s1;
	logic [pdrh_pkg::P8_W-1:0] pix8_s1;
	logic                      done_s1;
	logic                      ready_s1;
	logic                      rsp_valid_q;
	pdrh_pkg::rsp_t            rsp_q;

	logic                       advance;
	logic                       accept;
	logic                       commit;
	logic                       is_pixel;
	logic [pdrh_pkg::DEP_W-1:0] eff_depth;
	logic [FW-1:0]              frame_ext;
	logic [CW-1:0]              eff_frame;
	logic [pdrh_pkg::P8_W-1:0]  pix8;
	logic [IW-1:0]              pix_idx;
	logic [IW-1:0]              lookup_idx;
	logic                       in_range;
	pdrh_pkg::frame_ctl_t       ctl;
	logic [pdrh_pkg::CNT_W-1:0] count_s1;

	// Handshake
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;
	assign commit    = valid_s1 && advance;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;
	assign is_pixel  = (req_data.req_type == pdrh_pkg::REQ_PIXEL);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_depth_q    <= pdrh_pkg::BIT_DEPTH_RST;
			frame_pixels_q <= pdrh_pkg::FRAME_PIXELS_RST;
			input_8bit_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pdrh_pkg::CFG_BIT_DEPTH: begin
					bit_depth_q <= cfg_data[pdrh_pkg::DEP_W-1:0];
				end
				pdrh_pkg::CFG_FRAME_PIXELS: begin
					frame_pixels_q <= cfg_data[pdrh_pkg::CNT_W-1:0];
				end
				pdrh_pkg::CFG_INPUT_8BIT: begin
					input_8bit_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Clamp depth to 1..16 and frame size to 1..MAX_FRAME_PIXELS
	always_comb begin
		if (bit_depth_q == '0) begin
			eff_depth = pdrh_pkg::DEP_W'(1);
		end else if (bit_depth_q > pdrh_pkg::DEP_W'(16)) begin
			eff_depth = pdrh_pkg::DEP_W'(16);
		end else begin
			eff_depth = bit_depth_q;
		end
		frame_ext = FW'(frame_pixels_q);
		if (frame_ext == '0) begin
			eff_frame = CW'(1);
		end else if (frame_ext > MaxFrame) begin
			eff_frame = CW'(MAX_FRAME_PIXELS);
		end else begin
			eff_frame = frame_ext[CW-1:0];
		end
	end

	pdrh_scale #(
		.BIN_COUNT (BIN_COUNT)
	) u_scale (
		.pixel_value (req_data.pixel_value),
		.depth       (eff_depth),
		.is_8bit     (input_8bit_q),
		.pixel_8bit  (pix8),
		.bin_idx     (pix_idx)
	);

	// Bin looked up: the pixel's bin, or the requested bin for a read
	assign in_range   = ({1'b0, req_data.bin_index} < BinLimit);
	assign lookup_idx = is_pixel ? pix_idx : req_data.bin_index[IW-1:0];

	pdrh_frame #(
		.BIN_COUNT        (BIN_COUNT),
		.MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
	) u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.is_pixel  (is_pixel),
		.in_range  (in_range),
		.idx       (lookup_idx),
		.eff_frame (eff_frame),
		.ctl       (ctl)
	);

	pdrh_bins #(
		.BIN_COUNT (BIN_COUNT)
	) u_bins (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_en       (accept),
		.rd_addr     (lookup_idx),
		.rd_hit      (ctl.hit),
		.rd_is_pixel (is_pixel),
		.commit      (commit),
		.count_s1    (count_s1)
	);

	// Stage 1 valid and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (commit) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= req_data.req_type;
			pix8_s1  <= is_pixel ? pix8 : '0;
			done_s1  <= ctl.done;
			ready_s1 <= ctl.hist_ready;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q.reply_kind      <= kind_s1;
			rsp_q.pixel_8bit      <= pix8_s1;
			rsp_q.bin_count       <= count_s1;
			rsp_q.frame_done      <= done_s1;
			rsp_q.histogram_ready <= ready_s1;
		end
	end

endmodule

>>> tb/pixel_depth_reduce_histogram_tb.sv
`timescale 1ns / 1ps

module pixel_depth_reduce_histogram_tb;

	localparam int NUM_BINS       = 256;
	localparam int MAX_FRAME      = 1048576;
	localparam int RANDOM_ITEMS   = 400;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int REPORT_LIMIT   = 10;
	localparam int OWED_DEPTH     = 256;

	// Histogram predictor plus the ring of replies still owed by the block
	class hist_scoreboard_t;
		logic [pdrh_pkg::DEP_W-1:0] depth_reg;
		logic [pdrh_pkg::CNT_W-1:0] frame_reg;
		logic                       mode_8bit;
		logic [pdrh_pkg::CNT_W-1:0] bin_tally [NUM_BINS];
		int unsigned                pix_in_frame;
		logic                       frame_closed;
		pdrh_pkg::rsp_t             owed [OWED_DEPTH];
		int                         owed_wr;
		int                         owed_rd;
		int                         mismatches;
		int                         checked;
		int                         pixels_seen;
		int                         reads_seen;
		int                         frames_closed;
		int                         reg_writes;

		function new();
			depth_reg = pdrh_pkg::BIT_DEPTH_RST;
			frame_reg = pdrh_pkg::FRAME_PIXELS_RST;
			mode_8bit = 1'b0;
			foreach (bin_tally[i]) bin_tally[i] = '0;
			pix_in_frame = 0;
			frame_closed = 1'b0;
			owed_wr = 0;
			owed_rd = 0;
			mismatches = 0;
			checked = 0;
			pixels_seen = 0;
			reads_seen = 0;
			frames_closed = 0;
			reg_writes = 0;
		endfunction

		function void set_reg(logic [pdrh_pkg::CIX_W-1:0] idx,
				logic [pdrh_pkg::CFG_W-1:0] val);
			reg_writes++;
			case (idx)
				pdrh_pkg::CFG_BIT_DEPTH: depth_reg = val[pdrh_pkg::DEP_W-1:0];
				pdrh_pkg::CFG_FRAME_PIXELS: frame_reg = val[pdrh_pkg::CNT_W-1:0];
				pdrh_pkg::CFG_INPUT_8BIT: mode_8bit = val[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return owed_wr - owed_rd;
		endfunction

		// Work out the reply for one accepted request
		function void note_request(pdrh_pkg::req_t r);
			pdrh_pkg::rsp_t e;
			int unsigned    d, lim, v8, idx, fsize;
			e = '0;
			if (r.req_type == pdrh_pkg::REQ_READ) begin
				reads_seen++;
				e.reply_kind = pdrh_pkg::REQ_READ;
				e.bin_count = (r.bin_index < NUM_BINS) ? bin_tally[r.bin_index] : '0;
				e.histogram_ready = frame_closed;
			end else begin
				pixels_seen++;
				d = 32'(depth_reg);
				if (d < 1) d = 1;
				else if (d > 16) d = 16;
				// reduce to 8 bits, saturating
				if (mode_8bit)
					v8 = (r.pixel_value > 16'd255) ? 32'd255 : 32'(r.pixel_value);
				else begin
					v8 = (32'd255 * 32'(r.pixel_value)) >> d;
					if (v8 > 255) v8 = 255;
				end
				lim = 32'd1 << d;
				if (lim > NUM_BINS) lim = NUM_BINS;
				idx = (v8 >= lim) ? lim - 1 : v8;
				// first pixel of a frame: histogram starts from zero
				if (pix_in_frame == 0) begin
					foreach (bin_tally[i]) bin_tally[i] = '0;
					frame_closed = 1'b0;
				end
				if (bin_tally[idx] != pdrh_pkg::CNT_MAX)
					bin_tally[idx] = bin_tally[idx] + pdrh_pkg::CNT_W'(1);
				fsize = 32'(frame_reg);
				if (fsize < 1) fsize = 1;
				else if (fsize > MAX_FRAME) fsize = MAX_FRAME;
				pix_in_frame++;
				if (pix_in_frame >= fsize) begin
					pix_in_frame = 0;
					frame_closed = 1'b1;
					e.frame_done = 1'b1;
					frames_closed++;
				end
				e.reply_kind = pdrh_pkg::REQ_PIXEL;
				e.pixel_8bit = v8[pdrh_pkg::P8_W-1:0];
				e.bin_count = bin_tally[idx];
				e.histogram_ready = frame_closed;
			end
			owed[owed_wr % OWED_DEPTH] = e;
			owed_wr++;
		endfunction

		function void flag_error(string msg);
			mismatches++;
			if (mismatches <= REPORT_LIMIT) $display("MISMATCH %s", msg);
		endfunction

		// Compare one accepted reply with the oldest expectation
		function void check_reply(pdrh_pkg::rsp_t got);
			pdrh_pkg::rsp_t want;
			if (pending() == 0) begin
				flag_error($sformatf("reply with nothing pending: kind=%0d pix=%0d count=%0d",
					got.reply_kind, got.pixel_8bit, got.bin_count));
				return;
			end
			want = owed[owed_rd % OWED_DEPTH];
			owed_rd++;
			checked++;
			if (got.reply_kind !== want.reply_kind || got.pixel_8bit !== want.pixel_8bit ||
			    got.bin_count !== want.bin_count || got.frame_done !== want.frame_done ||
			    got.histogram_ready !== want.histogram_ready)
				flag_error({$sformatf("reply %0d: exp kind=%0d pix=%0d count=%0d done=%0d ",
					checked, want.reply_kind, want.pixel_8bit, want.bin_count,
					want.frame_done),
					$sformatf("ready=%0d / got kind=%0d pix=%0d count=%0d done=%0d ready=%0d",
					want.histogram_ready, got.reply_kind, got.pixel_8bit,
					got.bin_count, got.frame_done, got.histogram_ready)});
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       req_valid;
	logic                       req_stall;
	pdrh_pkg::req_t             req_data;
	logic                       rsp_valid;
	logic                       rsp_stall;
	pdrh_pkg::rsp_t             rsp_data;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [pdrh_pkg::CIX_W-1:0] cfg_index;
	logic [pdrh_pkg::CFG_W-1:0] cfg_data;

	hist_scoreboard_t sb;
	bit               tx_no_gaps = 1'b0;
	int               rx_hold_cycles = 0;
	int               idle_cycles = 0;

	pixel_depth_reduce_histogram dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Observe every transaction at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
			if (rsp_valid && !rsp_stall) sb.check_reply(rsp_data);
			if (req_valid && !req_stall) sb.note_request(req_data);
		end
	end

	// Watchdog: too long without any transaction
	always @(posedge clk) begin
		if (!arst_n || (cfg_valid && cfg_ready) || (req_valid && !req_stall) ||
		    (rsp_valid && !rsp_stall))
			idle_cycles = 0;
		else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles, %0d replies outstanding",
					idle_cycles, sb.pending());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Reply side: random stall runs, plus a long hold on request
	initial begin : reply_side
		int run_left;
		bit run_stalled;
		rsp_stall = 1'b0;
		run_left = 0;
		run_stalled = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				run_stalled = 1'b1;
				run_left = rx_hold_cycles;
				rx_hold_cycles = 0;
			end else if (run_left == 0) begin
				if (!run_stalled && $urandom_range(0, 1)) begin
					run_stalled = 1'b1;
					run_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
						: $urandom_range(10, 40);
				end else begin
					run_stalled = 1'b0;
					run_left = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4)
						: $urandom_range(20, 60);
				end
			end
			rsp_stall <= run_stalled;
			run_left--;
		end
	end

	function automatic int sender_gap();
		int pick;
		if (tx_no_gaps) return 0;
		pick = $urandom_range(0, 99);
		if (pick < 50) return 0;
		if (pick < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one request and hold it until the block takes it
	task automatic send_request(input pdrh_pkg::req_t r);
		int gap;
		gap = sender_gap();
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req_data <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic send_pixel(input logic [pdrh_pkg::PIX_W-1:0] v);
		pdrh_pkg::req_t r;
		r = '0;
		r.req_type = pdrh_pkg::REQ_PIXEL;
		r.pixel_value = v;
		send_request(r);
	endtask

	task automatic send_read(input logic [7:0] idx);
		pdrh_pkg::req_t r;
		r = '0;
		r.req_type = pdrh_pkg::REQ_READ;
		r.bin_index = idx;
		send_request(r);
	endtask

	// Stop sending and wait until every reply is back
	task automatic drain_replies();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [pdrh_pkg::CIX_W-1:0] idx,
			input logic [pdrh_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		pdrh_pkg::req_t             r;
		int                         phase, n, sent, d_eff, lim;
		logic [pdrh_pkg::DEP_W-1:0] dep;
		logic [pdrh_pkg::CFG_W-1:0] fp;
		logic                       m8;
		logic [pdrh_pkg::PIX_W-1:0] last_pix;

		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		cfg_valid = 1'b0;
		cfg_index = pdrh_pkg::CFG_BIT_DEPTH;
		cfg_data = '0;
		last_pix = '0;
		sb = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: untouched bins, scaling extremes at depth 8
		send_read(8'd0);
		send_read(8'hFF);
		send_pixel(16'h0000);
		send_pixel(16'hFFFF);
		send_pixel(16'h00FF);
		send_pixel(16'h0100);
		send_read(8'hFF);

		// Depth 0 acts as 1 and frame size 0 as 1: every pixel closes a frame
		drain_replies();
		cfg_write(pdrh_pkg::CFG_BIT_DEPTH, '0);
		cfg_write(pdrh_pkg::CFG_FRAME_PIXELS, '0);
		send_pixel(16'h0001);
		send_pixel(16'h0000);
		send_read(8'd0);
		send_read(8'd1);

		// Oversized depth and frame size clamp to their maximum
		drain_replies();
		cfg_write(pdrh_pkg::CFG_BIT_DEPTH, pdrh_pkg::CFG_W'(31));
		cfg_write(pdrh_pkg::CFG_FRAME_PIXELS, '1);
		send_pixel(16'hFFFF);
		send_pixel(16'h8000);
		send_pixel(16'h0001);

		// 8-bit mode: wide values saturate, indexes clamp to the last bin
		drain_replies();
		cfg_write(pdrh_pkg::CFG_INPUT_8BIT, pdrh_pkg::CFG_W'(1));
		cfg_write(pdrh_pkg::CFG_BIT_DEPTH, pdrh_pkg::CFG_W'(4));
		cfg_write(pdrh_pkg::CFG_FRAME_PIXELS, pdrh_pkg::CFG_W'(20));
		send_pixel(16'd300);
		send_pixel(16'h00AA);
		send_pixel(16'h0007);
		send_read(8'd15);

		// Frame size lowered below the pixels already taken
		drain_replies();
		cfg_write(pdrh_pkg::CFG_FRAME_PIXELS, pdrh_pkg::CFG_W'(1));
		send_pixel(16'h0005);
		send_read(8'd15);

		drain_replies();
		cfg_write(pdrh_pkg::CFG_BIT_DEPTH, pdrh_pkg::CFG_W'(17));
		cfg_write(pdrh_pkg::CFG_INPUT_8BIT, '0);
		send_pixel(16'hFFFF);
		send_read(8'd254);

		// Random phases, each with its own register setting
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			drain_replies();
			case (phase)
				0: begin
					dep = 5'd1;
					fp = pdrh_pkg::CFG_W'(1);
					m8 = 1'b0;
				end
				1: begin
					dep = 5'd16;
					fp = '1;
					m8 = 1'b1;
				end
				2: begin
					dep = '0;
					fp = '0;
					m8 = 1'b0;
				end
				default: begin
					dep = ($urandom_range(0, 3) == 0)
						? pdrh_pkg::DEP_W'($urandom_range(0, 31))
						: pdrh_pkg::DEP_W'($urandom_range(1, 16));
					fp = ($urandom_range(0, 7) == 0)
						? pdrh_pkg::CFG_W'($urandom_range(64, 600))
						: pdrh_pkg::CFG_W'($urandom_range(1, 32));
					m8 = 1'($urandom_range(0, 1));
				end
			endcase
			cfg_write(pdrh_pkg::CFG_BIT_DEPTH, pdrh_pkg::CFG_W'(dep));
			cfg_write(pdrh_pkg::CFG_FRAME_PIXELS, fp);
			cfg_write(pdrh_pkg::CFG_INPUT_8BIT, pdrh_pkg::CFG_W'(m8));
			d_eff = (dep < 5'd1) ? 1 : (dep > 5'd16) ? 16 : int'(dep);
			lim = (d_eff >= 8) ? NUM_BINS : (1 << d_eff);
			tx_no_gaps = (phase % 3 == 1);
			// receiver holds off while the sender keeps offering
			if (phase == 4) rx_hold_cycles = LONG_HOLD;
			n = $urandom_range(40, 60);
			repeat (n) begin
				r.req_type = ($urandom_range(0, 3) == 0) ? pdrh_pkg::REQ_READ
					: pdrh_pkg::REQ_PIXEL;
				r.pixel_value = pdrh_pkg::PIX_W'($urandom());
				r.bin_index = 8'($urandom());
				if (r.req_type == pdrh_pkg::REQ_PIXEL) begin
					case ($urandom_range(0, 4))
						0: r.pixel_value = last_pix;
						1: r.pixel_value = m8 ? pdrh_pkg::PIX_W'($urandom_range(0, 255))
							: pdrh_pkg::PIX_W'(r.pixel_value & ((1 << d_eff) - 1));
						2: r.pixel_value = $urandom_range(0, 1) ? '1 : '0;
						default: ;
					endcase
					last_pix = r.pixel_value;
				end else if ($urandom_range(0, 1))
					r.bin_index = 8'($urandom_range(0, lim - 1));
				send_request(r);
			end
			sent += n;
			phase++;
		end

		drain_replies();
		repeat (8) @(posedge clk);
		$display("Covered %0d pixels in %0d closed frames and %0d bin reads, %0d register writes",
			sb.pixels_seen, sb.frames_closed, sb.reads_seen, sb.reg_writes);
		$display("Replies checked: %0d, mismatches: %0d, still owed: %0d",
			sb.checked, sb.mismatches, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
